FILE: hw/rtl/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// shared types, constants and helpers of the pool integration step block
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int CNT_W   = 48;
    localparam int WORD_W  = 64;
    localparam int DT_W    = 32;
    localparam int VOL_W   = 32;
    localparam int RND_W   = 32;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 48;
    localparam int S_DATA_W = 224;
    localparam int M_DATA_W = 200;

    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [WORD_W-1:0] ONE_Q32     = 64'h1_0000_0000;
    localparam logic [WORD_W-1:0] ONE_Q24     = 64'h100_0000;
    localparam logic [WORD_W-1:0] VOL_ONE     = 64'h1_0000;
    localparam logic [WORD_W-1:0] LN2_Q32     = 64'd2977044472;
    localparam logic [WORD_W-1:0] X_LIMIT     = 64'd23 << 32;
    localparam logic [CNT_W-1:0]  STOCH_LIMIT = 48'd16777216000;
    localparam logic [3:0]        EXP_TERMS   = 4'd12;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_CONSERVE_MODE = 8'd0;
    localparam logic [IDX_W-1:0] REG_BUFFER_MODE   = 8'd1;
    localparam logic [IDX_W-1:0] REG_STOCHASTIC    = 8'd2;
    localparam logic [IDX_W-1:0] REG_TIME_STEP     = 8'd3;
    localparam logic [IDX_W-1:0] REG_VOLUME        = 8'd4;
    localparam logic [IDX_W-1:0] REG_INITIAL_COUNT = 8'd5;
    localparam logic [IDX_W-1:0] REG_FLOOR_COUNT   = 8'd6;
    localparam logic [IDX_W-1:0] REG_TOTAL_CONC    = 8'd7;

    localparam logic REQ_STEP    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic [1:0]       conserve_mode;
        logic             buffer_mode;
        logic             stochastic;
        logic [DT_W-1:0]  time_step;
        logic [VOL_W-1:0] volume;
        logic [CNT_W-1:0] initial_count;
        logic [CNT_W-1:0] floor_count;
        logic [CNT_W-1:0] total_conc;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } md_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] rem;
    } md_rsp_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_X,
        S_KR,
        S_TERM,
        S_T1,
        S_T2A,
        S_T2,
        S_GAIN,
        S_LOSS,
        S_FIN,
        S_CONC,
        S_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] sat48(input logic [WORD_W-1:0] v);
        sat48 = (v > {16'd0, CNT_MAX}) ? CNT_MAX : v[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] stoch_round(input logic [CNT_W-1:0] n,
                                                      input logic [RND_W-1:0] rnd);
        logic [CNT_W:0] base;
        base = {1'b0, n[CNT_W-1:24], 24'd0};
        if (rnd < {n[23:0], 8'd0}) begin
            base = base + {1'b0, 48'h100_0000};
        end
        stoch_round = base[CNT_W] ? CNT_MAX : base[CNT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/pis_cfg.sv
// ----------------------------------------------------------------------------
// pis_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module pis_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [pis_pkg::IDX_W-1:0]   wr_index,
    input  logic [pis_pkg::CFG_W-1:0]   wr_data,
    output pis_pkg::cfg_t               cfg
);

    pis_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conserve_mode <= '0;
            cfg_reg.buffer_mode   <= 1'b0;
            cfg_reg.stochastic    <= 1'b0;
            cfg_reg.time_step     <= 32'd16777216;
            cfg_reg.volume        <= 32'd65536;
            cfg_reg.initial_count <= '0;
            cfg_reg.floor_count   <= '0;
            cfg_reg.total_conc    <= '0;
        end else if (wr_en) begin
            case (wr_index)
                pis_pkg::REG_CONSERVE_MODE: cfg_reg.conserve_mode <= wr_data[1:0];
                pis_pkg::REG_BUFFER_MODE:   cfg_reg.buffer_mode   <= wr_data[0];
                pis_pkg::REG_STOCHASTIC:    cfg_reg.stochastic    <= wr_data[0];
                pis_pkg::REG_TIME_STEP:     cfg_reg.time_step     <= wr_data[31:0];
                pis_pkg::REG_VOLUME:        cfg_reg.volume        <= wr_data[31:0];
                pis_pkg::REG_INITIAL_COUNT: cfg_reg.initial_count <= wr_data;
                pis_pkg::REG_FLOOR_COUNT:   cfg_reg.floor_count   <= wr_data;
                pis_pkg::REG_TOTAL_CONC:    cfg_reg.total_conc    <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/pis_muldiv.sv
// ----------------------------------------------------------------------------
// pis_muldiv
// shared unit: floor(a*b/c) on a 128-bit product, saturating to all ones
// ----------------------------------------------------------------------------
module pis_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  pis_pkg::md_req_t  req,
    output pis_pkg::md_rsp_t  rsp
);

    pis_pkg::md_state_t state_reg, state_next;
    logic [1:0]  pp_idx_reg, pp_idx_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [63:0] rem_reg, rem_next, lo_reg, lo_next;

    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh, acc;
    logic [64:0]  trial;
    logic         ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pis_pkg::MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pp_idx_reg <= pp_idx_next;
        cnt_reg    <= cnt_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
    end

    always_comb begin
        state_next  = state_reg;
        pp_idx_next = pp_idx_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;

        // one 32x32 partial product a cycle
        ah    = pp_idx_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bh    = pp_idx_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp    = 64'(ah) * 64'(bh);
        case (pp_idx_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        acc   = {rem_reg, lo_reg} + pp_sh;
        trial = {rem_reg, lo_reg[63]};
        ge    = trial >= {1'b0, c_reg};

        case (state_reg)
            pis_pkg::MD_IDLE: begin
                if (req.start) begin
                    a_next      = req.a;
                    b_next      = req.b;
                    c_next      = req.c;
                    rem_next    = '0;
                    lo_next     = '0;
                    pp_idx_next = 2'd0;
                    state_next  = pis_pkg::MD_MUL;
                end
            end
            pis_pkg::MD_MUL: begin
                rem_next    = acc[127:64];
                lo_next     = acc[63:0];
                pp_idx_next = pp_idx_reg + 2'd1;
                if (pp_idx_reg == 2'd3) begin
                    state_next = pis_pkg::MD_CHK;
                end
            end
            pis_pkg::MD_CHK: begin
                cnt_next = '0;
                if (c_reg == '0 || rem_reg >= c_reg) begin
                    lo_next    = '1;
                    state_next = pis_pkg::MD_DONE;
                end else begin
                    state_next = pis_pkg::MD_DIV;
                end
            end
            pis_pkg::MD_DIV: begin
                // restoring step, quotient bits shift into the low word
                rem_next = ge ? 64'(trial - {1'b0, c_reg}) : trial[63:0];
                lo_next  = {lo_reg[62:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = pis_pkg::MD_DONE;
                end
            end
            pis_pkg::MD_DONE: begin
                state_next = pis_pkg::MD_IDLE;
            end
            default: state_next = pis_pkg::MD_IDLE;
        endcase
    end

    assign rsp.busy = state_reg != pis_pkg::MD_IDLE;
    assign rsp.done = state_reg == pis_pkg::MD_DONE;
    assign rsp.quot = lo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: hw/rtl/pool_integration_step.sv
// ----------------------------------------------------------------------------
// pool_integration_step
// advances one reagent pool count per item by exponential or plain euler
// ----------------------------------------------------------------------------
// s_ channel carries one step or restart item (s_tuser = req_type), m_ channel
// returns one result item per input item. configuration writes go over the
// cfg_ channel, which is always ready; write only while the block is idle.
// every product-quotient runs on one shared multiply-divide unit, which goes
// through 4 partial products, a check, 64 divide steps (skipped when the
// result saturates) and a done state. an exponential-euler step uses up to
// 18 unit operations, plain euler 3, restart, buffer and conserve items 1.
// s_tready is high only while no item is in work. the result sits in an
// output register; when the receiver stalls it holds there, the block may
// accept the next item, but that item's result waits until the register is
// taken. reset (aresetn low, synchronous) loads the register defaults and
// clears the pool count and total to zero.
// ----------------------------------------------------------------------------
module pool_integration_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // gain_sum, loss_sum, conserve_sum, total_sum, random_fraction
    input  logic [pis_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // count, remaining_count, concentration, remaining_conc, zero pad
    output logic [pis_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pis_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pis_pkg::CFG_W-1:0]     cfg_data
);

    pis_pkg::cfg_t    cfg;
    pis_pkg::md_req_t md_req;
    pis_pkg::md_rsp_t md_rsp;

    pis_pkg::state_t state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        req_reg, req_next;
    logic        do_floor_reg, do_floor_next;
    logic        do_limit_reg, do_limit_next;
    logic [47:0] count_now_reg, count_now_next;
    logic [47:0] total_reg, total_next;
    logic [47:0] n_reg, n_next;
    logic [47:0] gain_in_reg, gain_in_next, loss_in_reg, loss_in_next;
    logic [47:0] cons_reg, cons_next, tsum_reg, tsum_next;
    logic [31:0] rnd_reg, rnd_next;
    logic [63:0] x_reg, x_next;
    logic [5:0]  k_reg, k_next;
    logic [31:0] r_reg, r_next;
    logic [63:0] t_reg, t_next, sum_reg, sum_next;
    logic [3:0]  i_reg, i_next;
    logic [32:0] d_reg, d_next;
    logic [47:0] t1_reg, t1_next;
    logic [63:0] t2a_reg, t2a_next;
    logic [47:0] conc_reg, conc_next;
    logic        m_valid_reg, m_valid_next;
    logic [pis_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [63:0] sum_upd, sum_sh;
    logic [47:0] tot_c, n_c, fin_n;
    logic [48:0] add49, up49;
    logic [47:0] loss_c;
    logic [48:0] rem_cnt, rem_conc;
    logic [63:0] vol_w;

    pis_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pis_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == pis_pkg::S_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pis_pkg::S_IDLE;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            count_now_reg <= '0;
            total_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            m_valid_reg   <= m_valid_next;
            count_now_reg <= count_now_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        do_floor_reg <= do_floor_next;
        do_limit_reg <= do_limit_next;
        n_reg        <= n_next;
        gain_in_reg  <= gain_in_next;
        loss_in_reg  <= loss_in_next;
        cons_reg     <= cons_next;
        tsum_reg     <= tsum_next;
        rnd_reg      <= rnd_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        r_reg        <= r_next;
        t_reg        <= t_next;
        sum_reg      <= sum_next;
        i_reg        <= i_next;
        d_reg        <= d_next;
        t1_reg       <= t1_next;
        t2a_reg      <= t2a_next;
        conc_reg     <= conc_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        req_next       = req_reg;
        do_floor_next  = do_floor_reg;
        do_limit_next  = do_limit_reg;
        count_now_next = count_now_reg;
        total_next     = total_reg;
        n_next         = n_reg;
        gain_in_next   = gain_in_reg;
        loss_in_next   = loss_in_reg;
        cons_next      = cons_reg;
        tsum_next      = tsum_reg;
        rnd_next       = rnd_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        sum_next       = sum_reg;
        i_next         = i_reg;
        d_next         = d_reg;
        t1_next        = t1_reg;
        t2a_next       = t2a_reg;
        conc_next      = conc_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        md_req.start = 1'b0;
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.c     = '0;

        vol_w   = (cfg.volume == '0) ? pis_pkg::VOL_ONE : {32'd0, cfg.volume};
        sum_upd = i_reg[0] ? sum_reg - md_rsp.quot : sum_reg + md_rsp.quot;
        sum_sh  = sum_upd >> k_reg;

        tot_c = cfg.conserve_mode[0] ? tsum_reg : total_reg;
        n_c   = cfg.conserve_mode[1] ? ((tot_c > cons_reg) ? tot_c - cons_reg : '0)
                                     : tot_c;

        add49  = {1'b0, t1_reg} + {1'b0, pis_pkg::sat48(md_rsp.quot)};
        loss_c = pis_pkg::sat48(md_rsp.quot);
        up49   = {1'b0, n_reg} + {1'b0, gain_in_reg};

        fin_n = n_reg;
        if (do_floor_reg && fin_n < cfg.floor_count) begin
            fin_n = cfg.floor_count;
        end
        if (cfg.stochastic && (!do_limit_reg ||
                (fin_n < pis_pkg::STOCH_LIMIT && fin_n[23:0] != '0))) begin
            fin_n = pis_pkg::stoch_round(fin_n, rnd_reg);
        end

        rem_cnt  = {1'b0, total_reg} - {1'b0, n_reg};
        rem_conc = {1'b0, cfg.total_conc} - {1'b0, conc_reg};

        // operand selection for the shared unit
        case (state_reg)
            pis_pkg::S_X: begin
                md_req.a = {16'd0, loss_in_reg};
                md_req.b = {24'd0, cfg.time_step, 8'd0};
                md_req.c = {16'd0, n_reg};
            end
            pis_pkg::S_KR: begin
                md_req.a = x_reg;
                md_req.b = 64'd1;
                md_req.c = pis_pkg::LN2_Q32;
            end
            pis_pkg::S_TERM: begin
                md_req.a = t_reg;
                md_req.b = {32'd0, r_reg};
                md_req.c = {28'd0, i_reg, 32'd0};
            end
            pis_pkg::S_T1: begin
                md_req.a = {16'd0, n_reg};
                md_req.b = {31'd0, d_reg};
                md_req.c = pis_pkg::ONE_Q32;
            end
            pis_pkg::S_T2A: begin
                md_req.a = {16'd0, n_reg};
                md_req.b = {16'd0, gain_in_reg};
                md_req.c = {16'd0, loss_in_reg};
            end
            pis_pkg::S_T2: begin
                md_req.a = t2a_reg;
                md_req.b = pis_pkg::ONE_Q32 - {31'd0, d_reg};
                md_req.c = pis_pkg::ONE_Q32;
            end
            pis_pkg::S_GAIN: begin
                md_req.a = {16'd0, gain_in_reg};
                md_req.b = {32'd0, cfg.time_step};
                md_req.c = pis_pkg::ONE_Q24;
            end
            pis_pkg::S_LOSS: begin
                md_req.a = {16'd0, loss_in_reg};
                md_req.b = {32'd0, cfg.time_step};
                md_req.c = pis_pkg::ONE_Q24;
            end
            pis_pkg::S_CONC: begin
                md_req.a = {16'd0, n_reg};
                md_req.b = pis_pkg::VOL_ONE;
                md_req.c = vol_w;
            end
            default: ;
        endcase

        if (state_reg == pis_pkg::S_X || state_reg == pis_pkg::S_KR ||
            state_reg == pis_pkg::S_TERM || state_reg == pis_pkg::S_T1 ||
            state_reg == pis_pkg::S_T2A || state_reg == pis_pkg::S_T2 ||
            state_reg == pis_pkg::S_GAIN || state_reg == pis_pkg::S_LOSS ||
            state_reg == pis_pkg::S_CONC) begin
            if (!issued_reg) begin
                md_req.start = 1'b1;
                issued_next  = 1'b1;
            end else if (md_rsp.done) begin
                issued_next = 1'b0;
            end
        end

        case (state_reg)
            pis_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    req_next     = s_tuser;
                    gain_in_next = s_tdata[47:0];
                    loss_in_next = s_tdata[95:48];
                    cons_next    = s_tdata[143:96];
                    tsum_next    = s_tdata[191:144];
                    rnd_next     = s_tdata[223:192];
                    state_next   = pis_pkg::S_START;
                end
            end
            pis_pkg::S_START: begin
                do_floor_next = 1'b0;
                do_limit_next = 1'b0;
                state_next    = pis_pkg::S_FIN;
                if (req_reg == pis_pkg::REQ_RESTART) begin
                    n_next     = cfg.initial_count;
                    total_next = cfg.initial_count;
                end else if (cfg.buffer_mode) begin
                    n_next = cfg.initial_count;
                end else if (cfg.conserve_mode != '0) begin
                    total_next    = tot_c;
                    n_next        = n_c;
                    do_limit_next = 1'b1;
                end else begin
                    n_next        = count_now_reg;
                    do_floor_next = 1'b1;
                    do_limit_next = 1'b1;
                    if (count_now_reg != '0 && loss_in_reg != '0) begin
                        state_next = pis_pkg::S_X;
                    end else begin
                        state_next = pis_pkg::S_GAIN;
                    end
                end
            end
            pis_pkg::S_X: begin
                if (issued_reg && md_rsp.done) begin
                    x_next = md_rsp.quot;
                    if (md_rsp.quot >= pis_pkg::X_LIMIT) begin
                        d_next     = '0;
                        state_next = pis_pkg::S_T1;
                    end else begin
                        state_next = pis_pkg::S_KR;
                    end
                end
            end
            pis_pkg::S_KR: begin
                if (issued_reg && md_rsp.done) begin
                    k_next     = md_rsp.quot[5:0];
                    r_next     = md_rsp.rem[31:0];
                    t_next     = pis_pkg::ONE_Q32;
                    sum_next   = pis_pkg::ONE_Q32;
                    i_next     = 4'd1;
                    state_next = pis_pkg::S_TERM;
                end
            end
            pis_pkg::S_TERM: begin
                // taylor term t = t*r / (i * 2^32), alternating sign
                if (issued_reg && md_rsp.done) begin
                    t_next   = md_rsp.quot;
                    sum_next = sum_upd;
                    i_next   = i_reg + 4'd1;
                    if (i_reg == pis_pkg::EXP_TERMS) begin
                        d_next     = sum_sh[32:0];
                        state_next = pis_pkg::S_T1;
                    end
                end
            end
            pis_pkg::S_T1: begin
                if (issued_reg && md_rsp.done) begin
                    t1_next    = pis_pkg::sat48(md_rsp.quot);
                    state_next = pis_pkg::S_T2A;
                end
            end
            pis_pkg::S_T2A: begin
                if (issued_reg && md_rsp.done) begin
                    t2a_next   = md_rsp.quot;
                    state_next = pis_pkg::S_T2;
                end
            end
            pis_pkg::S_T2: begin
                if (issued_reg && md_rsp.done) begin
                    n_next     = add49[48] ? pis_pkg::CNT_MAX : add49[47:0];
                    state_next = pis_pkg::S_FIN;
                end
            end
            pis_pkg::S_GAIN: begin
                if (issued_reg && md_rsp.done) begin
                    // gain replaces the rate, which is no longer needed
                    gain_in_next = pis_pkg::sat48(md_rsp.quot);
                    state_next   = pis_pkg::S_LOSS;
                end
            end
            pis_pkg::S_LOSS: begin
                if (issued_reg && md_rsp.done) begin
                    if (up49 < {1'b0, loss_c}) begin
                        n_next = '0;
                    end else begin
                        n_next = pis_pkg::sat48({15'd0, up49 - {1'b0, loss_c}});
                    end
                    state_next = pis_pkg::S_FIN;
                end
            end
            pis_pkg::S_FIN: begin
                n_next         = fin_n;
                count_now_next = fin_n;
                state_next     = pis_pkg::S_CONC;
            end
            pis_pkg::S_CONC: begin
                if (issued_reg && md_rsp.done) begin
                    conc_next  = pis_pkg::sat48(md_rsp.quot);
                    state_next = pis_pkg::S_OUT;
                end
            end
            pis_pkg::S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {6'd0, rem_conc, conc_reg, rem_cnt, n_reg};
                    m_valid_next = 1'b1;
                    state_next   = pis_pkg::S_IDLE;
                end
            end
            default: state_next = pis_pkg::S_IDLE;
        endcase
    end

    // the shared unit is only started when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        md_req.start |-> !md_rsp.busy)
        else $error("shared unit started while busy");

    // an accepted item closes the input side on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after accept");

    // the unit never finishes an operation the sequencer did not ask for
    assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> (issued_reg && state_reg != pis_pkg::S_IDLE))
        else $error("unit result with no pending operation");

endmodule

FILE: tb/sv/pool_step_checker.sv
// ----------------------------------------------------------------------------
// pool_step_checker
// predicts every pool result from the accepted items and compares it
// ----------------------------------------------------------------------------
// watches the configuration channel and both streams, keeps its own copy of
// the registers, the pool count and the total, and queues one predicted result
// per accepted item. each accepted result is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module pool_step_checker
    import pis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [CNT_W:0]   remaining;
        logic [CNT_W-1:0] conc;
        logic [CNT_W:0]   remaining_conc;
    } pool_result_t;

    pool_result_t expected_results[$];

    cfg_t             regs;
    logic [CNT_W-1:0] pool_count;
    logic [CNT_W-1:0] pool_total;

    // floor(a*b/c), saturated to 64 bits
    function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c);
        logic [127:0] prod;
        logic [127:0] q;
        if (c == 0) begin
            return '1;
        end
        prod = {64'd0, a} * {64'd0, b};
        q = prod / {64'd0, c};
        return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic logic [CNT_W-1:0] clamp48(input logic [63:0] v);
        return (v > {16'd0, CNT_MAX}) ? CNT_MAX : v[CNT_W-1:0];
    endfunction

    // exp(-x), x in Q.32, by range reduction and a taylor sum
    function automatic logic [63:0] decay_factor(input logic [63:0] x);
        logic [63:0] k, r, t, sum;
        if (x >= X_LIMIT) begin
            return 64'd0;
        end
        k = x / LN2_Q32;
        r = x - k * LN2_Q32;
        t = ONE_Q32;
        sum = ONE_Q32;
        for (int i = 1; i <= 12; i++) begin
            t = ((t * r) >> 32) / i;
            if (i % 2 == 1) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
        end
        return sum >> k;
    endfunction

    function automatic logic [CNT_W-1:0] round_random(input logic [CNT_W-1:0] n,
                                                      input logic [RND_W-1:0] rnd);
        logic [CNT_W:0] base;
        base = {1'b0, n[CNT_W-1:24], 24'd0};
        if (rnd < {n[23:0], 8'd0}) begin
            base = base + 49'h100_0000;
        end
        return base[CNT_W] ? CNT_MAX : base[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] advance_count(input logic [CNT_W-1:0] n,
                                                       input logic [CNT_W-1:0] a,
                                                       input logic [CNT_W-1:0] b);
        logic [63:0] dt, x, d, t1, t2, gain, loss, up, res;
        dt = {32'd0, regs.time_step};
        if (n != 0 && b != 0) begin
            x = mul_div({16'd0, b}, dt << 8, {16'd0, n});
            d = decay_factor(x);
            t1 = mul_div({16'd0, n}, d, ONE_Q32);
            t2 = mul_div(mul_div({16'd0, n}, {16'd0, a}, {16'd0, b}), ONE_Q32 - d, ONE_Q32);
            res = {16'd0, clamp48({16'd0, clamp48(t1)} + {16'd0, clamp48(t2)})};
        end else begin
            gain = {16'd0, clamp48(mul_div({16'd0, a}, dt, ONE_Q24))};
            loss = {16'd0, clamp48(mul_div({16'd0, b}, dt, ONE_Q24))};
            up = {16'd0, n} + gain;
            res = (up < loss) ? 64'd0 : {16'd0, clamp48(up - loss)};
        end
        if (res[CNT_W-1:0] < regs.floor_count) begin
            res = {16'd0, regs.floor_count};
        end
        return res[CNT_W-1:0];
    endfunction

    function automatic pool_result_t predict_pool(input logic req,
                                                  input logic [S_DATA_W-1:0] d);
        logic [CNT_W-1:0] a, b, cons, tsum, n, conc;
        logic [RND_W-1:0] rnd;
        logic [63:0]      vol;
        pool_result_t     r;
        a    = d[47:0];
        b    = d[95:48];
        cons = d[143:96];
        tsum = d[191:144];
        rnd  = d[223:192];
        n = pool_count;
        if (req == REQ_RESTART) begin
            n = regs.initial_count;
            pool_total = regs.initial_count;
            if (regs.stochastic) n = round_random(n, rnd);
        end else if (regs.buffer_mode) begin
            n = regs.initial_count;
            if (regs.stochastic) n = round_random(n, rnd);
        end else begin
            if (regs.conserve_mode != 0) begin
                if (regs.conserve_mode[0]) begin
                    pool_total = tsum;
                    n = tsum;
                end
                if (regs.conserve_mode[1]) begin
                    n = (pool_total > cons) ? pool_total - cons : '0;
                end
            end else begin
                n = advance_count(n, a, b);
            end
            if (regs.stochastic && n < STOCH_LIMIT && n[23:0] != 0) begin
                n = round_random(n, rnd);
            end
        end
        pool_count = n;
        vol = (regs.volume == 0) ? VOL_ONE : {32'd0, regs.volume};
        conc = clamp48(mul_div({16'd0, n}, VOL_ONE, vol));
        r.count = n;
        r.remaining = {1'b0, pool_total} - {1'b0, n};
        r.conc = conc;
        r.remaining_conc = {1'b0, regs.total_conc} - {1'b0, conc};
        return r;
    endfunction

    always @(posedge aclk) begin
        pool_result_t exp_r;
        pool_result_t got;
        if (!aresetn) begin
            regs.conserve_mode = 2'd0;
            regs.buffer_mode = 1'b0;
            regs.stochastic = 1'b0;
            regs.time_step = 32'd16777216;
            regs.volume = 32'd65536;
            regs.initial_count = '0;
            regs.floor_count = '0;
            regs.total_conc = '0;
            pool_count = '0;
            pool_total = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CONSERVE_MODE: regs.conserve_mode = cfg_data[1:0];
                    REG_BUFFER_MODE:   regs.buffer_mode = cfg_data[0];
                    REG_STOCHASTIC:    regs.stochastic = cfg_data[0];
                    REG_TIME_STEP:     regs.time_step = cfg_data[31:0];
                    REG_VOLUME:        regs.volume = cfg_data[31:0];
                    REG_INITIAL_COUNT: regs.initial_count = cfg_data;
                    REG_FLOOR_COUNT:   regs.floor_count = cfg_data;
                    REG_TOTAL_CONC:    regs.total_conc = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.count = m_tdata[47:0];
                got.remaining = m_tdata[96:48];
                got.conc = m_tdata[144:97];
                got.remaining_conc = m_tdata[193:145];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: count %h", got.count);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.count !== exp_r.count || got.remaining !== exp_r.remaining ||
                        got.conc !== exp_r.conc ||
                        got.remaining_conc !== exp_r.remaining_conc) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp cnt %h rem %h conc %h rconc %h / got %h %h %h %h",
                                     exp_r.count, exp_r.remaining, exp_r.conc,
                                     exp_r.remaining_conc, got.count, got.remaining,
                                     got.conc, got.remaining_conc);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_pool(s_tuser, s_tdata));
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the pool integration step block
// ----------------------------------------------------------------------------
// runs a directed set over every mode and corner, then random phases with
// varied register settings and random idling on both streams; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    int                  fail_count;
    int                  pending;
    bit                  steady = 1'b0;
    int                  quiet_cycles = 0;

    pool_integration_step dut (.*);

    pool_step_checker checker_i (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // count of random magnitude, sometimes all ones
    function automatic logic [CNT_W-1:0] rand_count();
        logic [CNT_W-1:0] v;
        v = CNT_W'({$urandom, $urandom});
        if ($urandom_range(15) == 0) return CNT_MAX;
        return v >> $urandom_range(47);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_pool(input logic [1:0] cm, input logic bm, input logic st,
                            input logic [31:0] dt, input logic [31:0] vol,
                            input logic [CNT_W-1:0] init, input logic [CNT_W-1:0] flr,
                            input logic [CNT_W-1:0] tc);
        wait_drained();
        write_reg(REG_CONSERVE_MODE, {46'd0, cm});
        write_reg(REG_BUFFER_MODE, {47'd0, bm});
        write_reg(REG_STOCHASTIC, {47'd0, st});
        write_reg(REG_TIME_STEP, {16'd0, dt});
        write_reg(REG_VOLUME, {16'd0, vol});
        write_reg(REG_INITIAL_COUNT, init);
        write_reg(REG_FLOOR_COUNT, flr);
        write_reg(REG_TOTAL_CONC, tc);
    endtask

    task automatic push_item(input logic req, input logic [CNT_W-1:0] gain,
                             input logic [CNT_W-1:0] loss, input logic [CNT_W-1:0] cons,
                             input logic [CNT_W-1:0] tsum, input logic [RND_W-1:0] rnd);
        // s_tvalid is already low here
        while (!steady && $urandom_range(99) < 32) begin
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {rnd, tsum, cons, loss, gain};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_random(input int n);
        logic req;
        for (int i = 0; i < n; i++) begin
            req = ($urandom_range(9) == 0) ? REQ_RESTART : REQ_STEP;
            push_item(req, rand_count(), rand_count(), rand_count(), rand_count(), $urandom);
        end
    endtask

    initial begin
        logic [1:0] cm;
        logic [31:0] dt, vol;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: euler from zero, then exponential path
        push_item(REQ_STEP, 48'd0, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'h500_0000, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'h300_0000, 48'h100_0000, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, CNT_MAX, CNT_MAX, 48'd0, 48'd0, 32'hFFFF_FFFF);
        push_item(REQ_STEP, 48'd0, 48'd1, 48'd0, 48'd0, 32'd0);
        // euler saturating up, then going negative with a floor
        set_pool(2'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd0, 48'd0, 48'h10_0000, CNT_MAX);
        push_item(REQ_RESTART, 48'd0, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, CNT_MAX, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_RESTART, 48'd0, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'd0, CNT_MAX, 48'd0, 48'd0, 32'd0);
        // zero time step
        set_pool(2'd0, 1'b0, 1'b0, 32'd0, 32'd1, 48'h1234_5678, 48'd0, 48'd0);
        push_item(REQ_RESTART, 48'd0, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, CNT_MAX, 48'h100_0000, 48'd0, 48'd0, 32'd0);
        // sum-total, conserve, both, conserve below zero
        set_pool(2'd1, 1'b0, 1'b0, 32'd1, 32'hFFFF_FFFF, 48'd0, CNT_MAX, CNT_MAX);
        push_item(REQ_STEP, 48'd0, 48'd0, 48'd5, 48'h2_0000_0000, 32'd0);
        set_pool(2'd2, 1'b0, 1'b0, 32'd1, 32'd65536, 48'd0, 48'd0, 48'd0);
        push_item(REQ_STEP, 48'd0, 48'd0, 48'h1_0000_0000, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'd0, 48'd0, CNT_MAX, 48'd0, 32'd0);
        set_pool(2'd3, 1'b0, 1'b0, 32'd1, 32'd65536, 48'd0, 48'd0, 48'd0);
        push_item(REQ_STEP, 48'd0, 48'd0, 48'h1000, CNT_MAX, 32'd0);
        // buffer mode with stochastic rounding, and writes to two unused indexes
        set_pool(2'd0, 1'b1, 1'b1, 32'd16777216, 32'd65536, 48'h3_8000_00, 48'd0, 48'd0);
        write_reg(8'd8, CNT_MAX);
        write_reg(8'd255, 48'd0);
        push_item(REQ_STEP, 48'd0, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'd0, 48'd0, 48'd0, 48'd0, 32'hFFFF_FFFF);
        push_item(REQ_RESTART, 48'd0, 48'd0, 48'd0, 48'd0, 32'h7FFF_FFFF);
        // stochastic step below the limit
        set_pool(2'd0, 1'b0, 1'b1, 32'h80_0000, 32'd65536, CNT_MAX, 48'd0, 48'd0);
        push_item(REQ_STEP, 48'h1_8000, 48'd0, 48'd0, 48'd0, 32'd0);
        push_item(REQ_STEP, 48'h1_8000, 48'd0, 48'd0, 48'd0, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 9; phase++) begin
            cm = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd0;
            case ($urandom_range(3))
                0: dt = 32'd1;
                1: dt = 32'hFFFF_FFFF;
                default: dt = $urandom >> $urandom_range(31);
            endcase
            case ($urandom_range(3))
                0: vol = 32'd1;
                1: vol = 32'hFFFF_FFFF;
                2: vol = 32'd0;
                default: vol = $urandom;
            endcase
            set_pool(cm, $urandom_range(7) == 0, 1'($urandom_range(1)), dt, vol,
                     rand_count(), ($urandom_range(2) == 0) ? rand_count() : 48'd0,
                     rand_count());
            steady = (phase == 4);
            push_random(25);
            // hold off until the block has caught up
            wait_drained();
            push_random(25);
        end
        steady = 1'b0;

        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
